/* hdl/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and constants of the integer to ascii digits unit.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int HEX_DIGITS_MAX = 16;
    localparam int DEC_DIGITS_MAX = 10;
    localparam int RESULTS_MAX    = 16;

    // digit limits clamped to what the digit buffer holds
    localparam int HEX_LIM = (HEX_DIGITS_MAX < 1) ? 1 :
                             (HEX_DIGITS_MAX > RESULTS_MAX) ? RESULTS_MAX : HEX_DIGITS_MAX;
    localparam int DEC_LIM = (DEC_DIGITS_MAX < 1) ? 1 :
                             (DEC_DIGITS_MAX > RESULTS_MAX) ? RESULTS_MAX : DEC_DIGITS_MAX;

    localparam int DEC_BITS = 33;
    localparam int CNT_W    = $clog2(DEC_BITS);
    localparam int PTR_W    = $clog2(RESULTS_MAX);
    localparam int LIM_W    = $clog2(RESULTS_MAX + 1);

    localparam logic [1:0] MODE_DEC       = 2'd0;
    localparam logic [1:0] MODE_HEX_LOWER = 2'd1;
    localparam logic [1:0] MODE_HEX_UPPER = 2'd2;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_LO_A  = 7'h61;
    localparam logic [6:0] CHAR_UP_A  = 7'h41;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_UP_F  = 7'h46;
    localparam logic [6:0] CHAR_LO_F  = 7'h66;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  mode;
        logic        suppress_zero;
    } t_in;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
        logic       negative;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic emit_step;
    } t_dp_cmd;

    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic is_zero;
        logic suppress;
        logic overflow;
        logic digit_nz;
        logic ptr_zero;
    } t_dp_status;

endpackage

/* hdl/i2a_ctrl.sv */
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: conversion, leading zero scan and digit emission.
// ----------------------------------------------------------------------------
module i2a_ctrl
    import i2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (!i_status.is_dec || i_status.conv_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.is_zero && i_status.suppress) n_state = ST_IDLE;
                else if (i_status.overflow) n_state = ST_EMIT;
                else n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.digit_nz || i_status.ptr_zero) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.ptr_zero) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:  o_cmd.load      = start;
            ST_CONV:  o_cmd.conv_step = i_status.is_dec;
            ST_SCAN:  o_cmd.scan_step = !(i_status.digit_nz || i_status.ptr_zero);
            ST_EMIT:  o_cmd.emit_step = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

/* hdl/i2a_dp.sv */
// ----------------------------------------------------------------------------
// i2a_dp
// Datapath: binary to bcd shift register, digit buffer and output register.
// ----------------------------------------------------------------------------
module i2a_dp
    import i2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_strobe,
    output t_out       o_out
);

    logic [DEC_BITS-1:0]  r_bin;
    logic [15:0][3:0]     r_digits;
    logic [CNT_W-1:0]     r_cnt;
    logic [PTR_W-1:0]     r_ptr;
    logic                 r_dec;
    logic                 r_upper;
    logic                 r_neg;
    logic                 r_suppress;
    logic                 r_strobe;
    t_out                 r_out;

    logic [DEC_BITS-1:0]  n_mag;
    logic [15:0][3:0]     n_adj;
    logic [3:0]           n_digit;
    logic [6:0]           n_char;
    logic [LIM_W-1:0]     n_lim;
    logic                 n_ovf;
    logic                 n_is_dec;

    assign n_is_dec = (i_in.mode == MODE_DEC);
    // two's complement magnitude of the low 33 bits, -2^32 maps to 2^32
    assign n_mag = i_in.value[DEC_BITS-1] ? (~i_in.value[DEC_BITS-1:0] + 1'b1)
                                          : i_in.value[DEC_BITS-1:0];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_adj[i] = (r_digits[i] >= 4'd5) ? (r_digits[i] + 4'd3) : r_digits[i];
        end
    end

    // any nonzero digit above the emitted window
    assign n_lim = r_dec ? LIM_W'(DEC_LIM) : LIM_W'(HEX_LIM);
    always_comb begin
        n_ovf = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if ((LIM_W'(i) >= n_lim) && (r_digits[i] != 4'd0)) n_ovf = 1'b1;
        end
    end

    assign n_digit = r_digits[r_ptr];
    always_comb begin
        if (n_digit <= 4'd9) n_char = CHAR_ZERO + {3'b000, n_digit};
        else n_char = (r_upper ? CHAR_UP_A : CHAR_LO_A) + {3'b000, n_digit} - 7'd10;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec      <= n_is_dec;
            r_upper    <= (i_in.mode != MODE_HEX_LOWER);
            r_neg      <= n_is_dec && i_in.value[DEC_BITS-1];
            r_suppress <= i_in.suppress_zero;
            r_bin      <= n_mag;
            r_digits   <= n_is_dec ? '0 : i_in.value;
            r_cnt      <= '0;
            r_ptr      <= n_is_dec ? PTR_W'(DEC_LIM - 1) : PTR_W'(HEX_LIM - 1);
        end else if (i_cmd.conv_step) begin
            // shift the adjusted bcd digits left, next binary bit enters at the bottom
            r_digits <= {n_adj[15][2:0], n_adj[14:0], r_bin[DEC_BITS-1]};
            r_bin    <= {r_bin[DEC_BITS-2:0], 1'b0};
            r_cnt    <= r_cnt + 1'b1;
        end else if ((i_cmd.scan_step || i_cmd.emit_step) && (r_ptr != '0)) begin
            r_ptr <= r_ptr - 1'b1;
        end
        if (i_cmd.emit_step) begin
            r_out.digit_char <= n_char;
            r_out.last       <= (r_ptr == '0);
            r_out.negative   <= r_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_step;
        end
    end

    assign o_status.is_dec    = r_dec;
    assign o_status.conv_done = (r_cnt == CNT_W'(DEC_BITS - 1));
    assign o_status.is_zero   = (r_digits == '0);
    assign o_status.suppress  = r_suppress;
    assign o_status.overflow  = n_ovf;
    assign o_status.digit_nz  = (n_digit != 4'd0);
    assign o_status.ptr_zero  = (r_ptr == '0);

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

/* hdl/integer_to_ascii_digits_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_unit
// Converts one number to its ascii digits, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_in and raise start while busy is low; the transaction is taken at
//   that edge and busy rises on the next cycle.
//   Decimal mode: a load, 33 double dabble shifts, a check, a leading zero
//   scan over up to 10 digits, then one digit per cycle.
//   Hex modes: a load, a conversion pass-through, a check, a scan over up
//   to 16 digits, then one digit per cycle.
//   Scan and emit together walk the whole digit window, so busy lasts the
//   same whatever the digit count; a new transaction is taken only once
//   busy falls. A suppressed zero frees the unit right after the check.
//   Each digit appears on o_out for one cycle with o_strobe high, in the
//   cycle after it is selected; o_out.last marks the final digit.
//   busy falls as the last digit is registered, so the next start may be
//   taken while that digit is still on the ports.
//   A zero value with suppress_zero set produces no strobes at all.
//   Reset clears the sequencer and the strobe, so no result is made up; a conversion in flight is dropped.
//   The receiver cannot stall: results must be taken when strobed.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_unit
    import i2a_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    i2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    i2a_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

/* hdl/i2a_chk.sv */
// ----------------------------------------------------------------------------
// i2a_chk
// Port level checks of the integer to ascii digits unit.
// ----------------------------------------------------------------------------
module i2a_chk
    import i2a_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_in,
    input logic o_strobe,
    input t_out o_out
);

    // an accepted transaction keeps the unit busy on the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // digits of one number come out in consecutive cycles
    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.last) |=> o_strobe)
        else $error("gap inside a digit string");

    // a strobed character is a decimal or hex digit
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_out.digit_char >= CHAR_ZERO && o_out.digit_char <= CHAR_NINE) ||
                      (o_out.digit_char >= CHAR_UP_A && o_out.digit_char <= CHAR_UP_F) ||
                      (o_out.digit_char >= CHAR_LO_A && o_out.digit_char <= CHAR_LO_F)))
        else $error("illegal digit character");

    // negative only goes with decimal characters
    a_neg_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.negative) |-> (o_out.digit_char <= CHAR_NINE))
        else $error("negative flag on a hex digit");

endmodule

bind integer_to_ascii_digits_unit i2a_chk u_i2a_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);
